[rtl/m3i_pkg.sv]
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared types and widths of the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int ElemBits = 32;
  localparam int FracBits = 16;
  localparam int ProdBits = 2 * ElemBits;
  localparam int CofBits  = ProdBits + 1;
  localparam int DetBits  = ElemBits + CofBits + 2;
  localparam int NumBits  = CofBits + 2 * FracBits;
  localparam int CandBits = DetBits + ElemBits - 1;

  typedef struct packed {
    logic signed [ElemBits-1:0] a00;
    logic signed [ElemBits-1:0] a01;
    logic signed [ElemBits-1:0] a02;
    logic signed [ElemBits-1:0] a10;
    logic signed [ElemBits-1:0] a11;
    logic signed [ElemBits-1:0] a12;
    logic signed [ElemBits-1:0] a20;
    logic signed [ElemBits-1:0] a21;
    logic signed [ElemBits-1:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [ElemBits-1:0] inv00;
    logic signed [ElemBits-1:0] inv01;
    logic signed [ElemBits-1:0] inv02;
    logic signed [ElemBits-1:0] inv10;
    logic signed [ElemBits-1:0] inv11;
    logic signed [ElemBits-1:0] inv12;
    logic signed [ElemBits-1:0] inv20;
    logic signed [ElemBits-1:0] inv21;
    logic signed [ElemBits-1:0] inv22;
    logic                       singular;
    logic                       saturated;
  } out_t;

  typedef struct packed {
    logic [8:0][CofBits-1:0] adj;
    logic [DetBits-1:0]      det;
    in_t                     mat;
  } fb_t;

  typedef struct packed {
    logic [8:0][NumBits-1:0]  rem;
    logic [8:0][ElemBits-1:0] quo;
    logic [8:0]               big;
    logic [8:0]               neg;
    logic [DetBits-1:0]       ud;
    logic                     sing;
    in_t                      mat;
  } dv_t;

  localparam logic [ElemBits-1:0] ElemMax = {1'b0, {(ElemBits-1){1'b1}}};
  localparam logic [ElemBits-1:0] ElemMin = {1'b1, {(ElemBits-1){1'b0}}};

endpackage

[rtl/matrix_3x3_inverse.sv]
// ----------------------------------------------------------------------------
// matrix_3x3_inverse
// Inverse of a 3x3 signed Q16.16 matrix through the adjugate.
// ----------------------------------------------------------------------------
// Accepts one matrix per clock and delivers one inverse per clock while the
// result side keeps popping. On the way from push to the output, five
// front stages form the cofactors and the determinant, the result passes
// the two-entry queue, and the back end takes one setup stage, 32 divider
// stages (one quotient bit per stage for all nine elements) and the output
// register. The 32-stage divider pipeline sets the latency. Quotients
// truncate toward zero and clip to the Q16.16 range with saturated set; a
// zero determinant returns the input matrix with singular set and
// saturated clear.
// ----------------------------------------------------------------------------
module matrix_3x3_inverse import m3i_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  in_i,
  output logic empty,
  input  logic pop,
  output out_t out_o
);

  logic fb_valid, fb_ready, bk_valid, bk_pop;
  fb_t  fb, bk;

  m3i_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_i       (in_i),
    .fb_valid_o (fb_valid),
    .fb_ready_i (fb_ready),
    .fb_o       (fb)
  );

  m3i_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (fb_valid),
    .ready_o (fb_ready),
    .wdata_i (fb),
    .valid_o (bk_valid),
    .rd_i    (bk_pop),
    .rdata_o (bk)
  );

  m3i_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fb_valid_i (bk_valid),
    .fb_pop_o   (bk_pop),
    .fb_i       (bk),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_o      (out_o)
  );

endmodule

[rtl/m3i_front.sv]
// ----------------------------------------------------------------------------
// m3i_front
// Input stage: cofactors, adjugate and determinant in five pipeline stages.
// ----------------------------------------------------------------------------
module m3i_front import m3i_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  in_t  in_i,
  output logic fb_valid_o,
  input  logic fb_ready_i,
  output fb_t  fb_o
);

  logic                       en;
  logic [4:0]                 v_q, v_d;
  in_t                        mat1_q, mat2_q, mat3_q, mat4_q;
  logic signed [ProdBits-1:0] prod_q [18];
  logic signed [ProdBits-1:0] prod_d [18];
  logic signed [CofBits-1:0]  cof_q [9];
  logic signed [CofBits-1:0]  cof_d [9];
  logic signed [CofBits-1:0]  cof4_q [9];
  logic signed [CofBits-1:0]  dhi_q [3];
  logic signed [CofBits-1:0]  dhi_d [3];
  logic signed [CofBits-1:0]  dlo_q [3];
  logic signed [CofBits-1:0]  dlo_d [3];
  logic signed [ElemBits-1:0] a [9];
  fb_t                        fb_q, fb_d;

  function automatic logic signed [ElemBits-1:0] a1_at(input int r, input int c);
    logic [8:0][ElemBits-1:0] m;
    m = {mat1_q.a22, mat1_q.a21, mat1_q.a20, mat1_q.a12, mat1_q.a11,
         mat1_q.a10, mat1_q.a02, mat1_q.a01, mat1_q.a00};
    return $signed(m[3*r+c]);
  endfunction

  assign en         = !v_q[4] || fb_ready_i;
  assign full_o     = !en;
  assign fb_valid_o = v_q[4];
  assign fb_o       = fb_q;
  assign v_d        = {v_q[3:0], push_i};

  always_comb begin
    a = '{mat3_q.a00, mat3_q.a01, mat3_q.a02, mat3_q.a10, mat3_q.a11,
          mat3_q.a12, mat3_q.a20, mat3_q.a21, mat3_q.a22};
  end

  // products of the 2x2 minors: cofactor (i,j) uses rows i+1, i+2 and columns j+1, j+2
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[2*(3*i+j)]   = a1_at((i+1)%3, (j+1)%3) * a1_at((i+2)%3, (j+2)%3);
        prod_d[2*(3*i+j)+1] = a1_at((i+1)%3, (j+2)%3) * a1_at((i+2)%3, (j+1)%3);
      end
    end
    for (int k = 0; k < 9; k++) begin
      cof_d[k] = CofBits'(prod_q[2*k]) - CofBits'(prod_q[2*k+1]);
    end
    for (int j = 0; j < 3; j++) begin
      dhi_d[j] = CofBits'(a[j] * $signed(cof_q[j][CofBits-1:ElemBits]));
      dlo_d[j] = CofBits'(a[j] * $signed({1'b0, cof_q[j][ElemBits-1:0]}));
    end
    fb_d.det = '0;
    for (int j = 0; j < 3; j++) begin
      fb_d.det = fb_d.det + (DetBits'(dhi_q[j]) <<< ElemBits) + DetBits'(dlo_q[j]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        fb_d.adj[3*i+j] = cof4_q[3*j+i];
      end
    end
    fb_d.mat = mat4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mat1_q <= in_i;
      mat2_q <= mat1_q;
      mat3_q <= mat2_q;
      mat4_q <= mat3_q;
      prod_q <= prod_d;
      cof_q  <= cof_d;
      cof4_q <= cof_q;
      dhi_q  <= dhi_d;
      dlo_q  <= dlo_d;
      fb_q   <= fb_d;
    end
  end

endmodule

[rtl/m3i_fifo.sv]
// ----------------------------------------------------------------------------
// m3i_fifo
// Two-entry queue between the cofactor front end and the divider back end.
// ----------------------------------------------------------------------------
module m3i_fifo import m3i_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  output logic ready_o,
  input  fb_t  wdata_i,
  output logic valid_o,
  input  logic rd_i,
  output fb_t  rdata_o
);

  fb_t        mem [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign wr      = wr_i && ready_o;
  assign rd      = rd_i && valid_o;
  assign rdata_o = mem[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr) begin
        wptr_q <= !wptr_q;
      end
      if (rd) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem[wptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/m3i_back.sv]
// ----------------------------------------------------------------------------
// m3i_back
// Divider back end: nine restoring dividers, one quotient bit per stage,
// followed by sign, saturation and the singular bypass.
// ----------------------------------------------------------------------------
module m3i_back import m3i_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fb_valid_i,
  output logic fb_pop_o,
  input  fb_t  fb_i,
  output logic empty_o,
  input  logic pop_i,
  output out_t out_o
);

  logic                en;
  logic [ElemBits:0]   vld_q;
  dv_t                 st_q [ElemBits+1];
  dv_t                 st_d [ElemBits+1];
  logic                out_v_q;
  out_t                out_q, out_d;
  logic [DetBits-1:0]  det_s;
  logic [CofBits-1:0]  cmag;
  logic [CandBits-1:0] cand;
  logic [CandBits-1:0] remx;
  logic [ElemBits-1:0] qv [9];
  logic [8:0]          sat;

  assign en       = !out_v_q || pop_i;
  assign fb_pop_o = en && fb_valid_i;
  assign empty_o  = !out_v_q;
  assign out_o    = out_q;

  always_comb begin
    det_s         = fb_i.det;
    st_d[0]       = '0;
    st_d[0].ud    = det_s[DetBits-1] ? (~det_s + 1'b1) : det_s;
    st_d[0].sing  = (det_s == '0);
    st_d[0].mat   = fb_i.mat;
    for (int k = 0; k < 9; k++) begin
      cmag = fb_i.adj[k][CofBits-1] ? (~fb_i.adj[k] + 1'b1) : fb_i.adj[k];
      st_d[0].rem[k] = {cmag, {(2*FracBits){1'b0}}};
      st_d[0].neg[k] = fb_i.adj[k][CofBits-1] ^ det_s[DetBits-1];
      st_d[0].big[k] = (DetBits'(cmag) >= st_d[0].ud);
    end
    for (int s = 1; s <= ElemBits; s++) begin
      st_d[s] = st_q[s-1];
      cand    = CandBits'(st_q[s-1].ud) << (ElemBits - s);
      for (int k = 0; k < 9; k++) begin
        remx = CandBits'(st_q[s-1].rem[k]);
        if (remx >= cand) begin
          st_d[s].rem[k] = NumBits'(remx - cand);
          st_d[s].quo[k][ElemBits-s] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (st_q[ElemBits].neg[k]) begin
        sat[k] = st_q[ElemBits].big[k] ||
                 (st_q[ElemBits].quo[k][ElemBits-1] &&
                  (st_q[ElemBits].quo[k][ElemBits-2:0] != '0));
        qv[k]  = sat[k] ? ElemMin : (~st_q[ElemBits].quo[k] + 1'b1);
      end else begin
        sat[k] = st_q[ElemBits].big[k] || st_q[ElemBits].quo[k][ElemBits-1];
        qv[k]  = sat[k] ? ElemMax : st_q[ElemBits].quo[k];
      end
    end
    if (st_q[ElemBits].sing) begin
      out_d = {st_q[ElemBits].mat, 1'b1, 1'b0};
    end else begin
      out_d = {qv[0], qv[1], qv[2], qv[3], qv[4], qv[5], qv[6], qv[7], qv[8],
               1'b0, |sat};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      vld_q   <= {vld_q[ElemBits-1:0], fb_valid_i};
      out_v_q <= vld_q[ElemBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q  <= st_d;
      out_q <= out_d;
    end
  end

endmodule

[rtl/m3i_checker.sv]
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks of the matrix inverse, bound to the top level.
// ----------------------------------------------------------------------------
module m3i_checker import m3i_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic push,
  input logic full,
  input logic empty,
  input logic pop,
  input out_t out_o
);

  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_o))
    else $error("waiting result changed");

  a_sing_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(out_o.singular && out_o.saturated))
    else $error("singular result flagged saturated");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_o.saturated |->
      out_o.inv00 == ElemMax || out_o.inv00 == ElemMin ||
      out_o.inv01 == ElemMax || out_o.inv01 == ElemMin ||
      out_o.inv02 == ElemMax || out_o.inv02 == ElemMin ||
      out_o.inv10 == ElemMax || out_o.inv10 == ElemMin ||
      out_o.inv11 == ElemMax || out_o.inv11 == ElemMin ||
      out_o.inv12 == ElemMax || out_o.inv12 == ElemMin ||
      out_o.inv20 == ElemMax || out_o.inv20 == ElemMin ||
      out_o.inv21 == ElemMax || out_o.inv21 == ElemMin ||
      out_o.inv22 == ElemMax || out_o.inv22 == ElemMin)
    else $error("saturated without a clipped element");

  a_push_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && full |-> !empty)
    else $error("input stalled with no result waiting");

endmodule

bind matrix_3x3_inverse m3i_checker u_m3i_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);

[tb/sv/matrix_3x3_inverse_tb.sv]
// ----------------------------------------------------------------------------
// matrix_3x3_inverse_tb
// Self-checking bench for the 3x3 Q16.16 matrix inverse. An exact wide
// integer model predicts every inverse, the saturation and the singular
// case. Directed matrices come first, then random ones: well-conditioned,
// singular and raw. Both handshake sides idle at random, and the result
// side holds off long enough to fill the block.
// ----------------------------------------------------------------------------
module matrix_3x3_inverse_tb;
  import m3i_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [191:0] wide_t;

  localparam int CycleLimit = 200000;
  localparam int HoldStart  = 200;
  localparam int HoldLen    = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  in_t  in_i = '0;
  out_t out_o;

  in_t  pend_mat_q[$];
  out_t exp_inv_q[$];
  int   n_in = 0;
  int   n_out = 0;
  int   n_err = 0;
  int   cycles = 0;
  int   hold_cnt = 0;
  bit   hold_done = 1'b0;
  bit   in_xfer = 1'b0;

  matrix_3x3_inverse u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .in_i  (in_i),
    .empty (empty),
    .pop   (pop),
    .out_o (out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_t invert_matrix(in_t a);
    logic [8:0][31:0] ia;
    logic [8:0][31:0] rv;
    wide_t m[3][3];
    wide_t c[3][3];
    wide_t det, q, mx, mn;
    logic sat;
    ia = a;
    sat = 1'b0;
    mx = 192'sd2147483647;
    mn = -192'sd2147483648;
    for (int k = 0; k < 9; k++) m[k/3][k%3] = wide_t'($signed(ia[8-k]));
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
                - m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
      end
    end
    det = m[0][0] * c[0][0] + m[0][1] * c[0][1] + m[0][2] * c[0][2];
    if (det == 0) begin
      return {ia, 1'b1, 1'b0};
    end
    for (int k = 0; k < 9; k++) begin
      q = (c[k%3][k/3] <<< (2 * FracBits)) / det;
      if (q > mx) begin
        q = mx;
        sat = 1'b1;
      end else if (q < mn) begin
        q = mn;
        sat = 1'b1;
      end
      rv[8-k] = q[31:0];
    end
    return {rv, 1'b0, sat};
  endfunction

  function automatic logic [31:0] rnd_elem(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      default: return 32'($urandom_range(0, 1 << 9)) - 32'(1 << 8);
    endcase
  endfunction

  function automatic in_t rnd_matrix();
    logic [8:0][31:0] e;
    int kind, mode;
    kind = $urandom_range(0, 99);
    mode = (kind < 15) ? 0 : (kind < 90 ? 1 : 2);
    for (int k = 0; k < 9; k++) e[k] = rnd_elem(mode);
    if (kind >= 30 && kind < 75) begin
      e[8] += 32'h0004_0000;
      e[4] += 32'h0004_0000;
      e[0] += 32'h0004_0000;
    end else if (kind >= 75 && kind < 85) begin
      case ($urandom_range(0, 2))
        0: begin e[2] = e[8]; e[1] = e[7]; e[0] = e[6]; end
        1: begin e[8] = e[7]; e[5] = e[4]; e[2] = e[1]; end
        default: begin e[5] = 0; e[4] = 0; e[3] = 0; end
      endcase
    end
    return e;
  endfunction

  function automatic in_t diag(logic [31:0] d0, logic [31:0] d1, logic [31:0] d2);
    logic [8:0][31:0] e;
    e = '0;
    e[8] = d0;
    e[4] = d1;
    e[0] = d2;
    return e;
  endfunction

  task automatic chk(string name, logic [31:0] x, logic [31:0] y);
    if (x !== y) begin
      $error("%s expected %h actual %h", name, x, y);
      n_err++;
    end
  endtask

  // posedge: record transfers on both sides
  always @(posedge clk_i) begin
    out_t e;
    cycles <= cycles + 1;
    in_xfer <= rst_ni && push && !full;
    if (rst_ni && push && !full) begin
      exp_inv_q.push_back(invert_matrix(in_i));
      n_in <= n_in + 1;
    end
    if (rst_ni && pop && !empty) begin
      n_out <= n_out + 1;
      if (exp_inv_q.size() == 0) begin
        $error("result with no expectation");
        n_err++;
      end else begin
        e = exp_inv_q.pop_front();
        chk("inv00", e.inv00, out_o.inv00);
        chk("inv01", e.inv01, out_o.inv01);
        chk("inv02", e.inv02, out_o.inv02);
        chk("inv10", e.inv10, out_o.inv10);
        chk("inv11", e.inv11, out_o.inv11);
        chk("inv12", e.inv12, out_o.inv12);
        chk("inv20", e.inv20, out_o.inv20);
        chk("inv21", e.inv21, out_o.inv21);
        chk("inv22", e.inv22, out_o.inv22);
        chk("singular", 32'(e.singular), 32'(out_o.singular));
        chk("saturated", 32'(e.saturated), 32'(out_o.saturated));
      end
    end
    if (cycles > CycleLimit) begin
      $display("matrix_3x3_inverse_tb NOT OK");
      $finish;
    end
  end

  // negedge: sender
  always @(negedge clk_i) begin
    bit busy;
    busy = (n_in > 400 && n_in < 560);
    if (rst_ni && (!push || in_xfer)) begin
      if (pend_mat_q.size() != 0 && (busy || $urandom_range(0, 99) >= 23)) begin
        push <= 1'b1;
        in_i <= pend_mat_q.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  // negedge: receiver, with one long hold-off
  always @(negedge clk_i) begin
    bit busy;
    busy = (n_in > 400 && n_in < 560);
    if (rst_ni) begin
      if (!hold_done && n_out >= HoldStart) begin
        hold_done <= 1'b1;
        hold_cnt <= HoldLen;
        pop <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        pop <= 1'b0;
      end else begin
        pop <= busy || $urandom_range(0, 99) >= 23;
      end
    end
  end

  initial begin
    logic [8:0][31:0] e;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    pend_mat_q.push_back(diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    pend_mat_q.push_back('0);
    pend_mat_q.push_back({9{32'h7fff_ffff}});
    pend_mat_q.push_back({9{32'h8000_0000}});
    pend_mat_q.push_back({9{32'hffff_ffff}});
    pend_mat_q.push_back(diag(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    pend_mat_q.push_back(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pend_mat_q.push_back(diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
    pend_mat_q.push_back(diag(32'h0000_0100, 32'h0001_0000, 32'h0100_0000));
    pend_mat_q.push_back(diag(32'hffff_0000, 32'h0002_0000, 32'h0000_8000));
    pend_mat_q.push_back(diag(32'h0003_0000, 32'h0003_0000, 32'h0003_0000));
    pend_mat_q.push_back(diag(32'hfffd_0000, 32'h0007_0000, 32'hffff_0000));
    e = {32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
         32'h0004_0000, 32'h0005_0000, 32'h0006_0000,
         32'h0007_0000, 32'h0008_0000, 32'h000a_0000};
    pend_mat_q.push_back(e);
    e[0] = 32'h0009_0000;
    pend_mat_q.push_back(e);
    e = {32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
         32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
         32'h0000_0000, 32'h0000_0000, 32'hffff_0000};
    pend_mat_q.push_back(e);
    e = {32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001,
         32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
         32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff};
    pend_mat_q.push_back(e);
    pend_mat_q.push_back(diag(32'h0000_0001, 32'h0001_0000, 32'h7fff_ffff));
    pend_mat_q.push_back(diag(32'h5555_5555, 32'haaaa_aaaa, 32'h0001_0000));
    for (int k = 0; k < 4; k++) pend_mat_q.push_back(rnd_matrix());
    wait (pend_mat_q.size() == 0 && !push && exp_inv_q.size() == 0);
    for (int k = 0; k < 900; k++) pend_mat_q.push_back(rnd_matrix());
    wait (pend_mat_q.size() == 0 && !push);
    wait (exp_inv_q.size() == 0);
    repeat (60) @(posedge clk_i);
    if (n_err == 0 && exp_inv_q.size() == 0) begin
      $display("matrix_3x3_inverse_tb OK");
    end else begin
      if (exp_inv_q.size() != 0) $error("expectations left over");
      $display("matrix_3x3_inverse_tb NOT OK");
    end
    $finish;
  end

endmodule
